// ----- rtl/pmmu_pkg.sv -----
// shared types and constants for the paged mmu with fifo replacement
package pmmu_pkg;

  localparam int MAX_PAGES_DEF  = 256;
  localparam int MAX_FRAMES_DEF = 64;

  localparam int VADDR_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int SHIFT_W     = 5;
  localparam int NPAGES_W    = 9;
  localparam int NFRAMES_W   = 7;
  localparam int EVICT_W     = 8;
  localparam int FRAME_OUT_W = 6;

  localparam logic [SHIFT_W-1:0]   PAGE_SHIFT_RST = 5'd12;
  localparam logic [NPAGES_W-1:0]  NUM_PAGES_RST  = 9'd256;
  localparam logic [NFRAMES_W-1:0] NUM_FRAMES_RST = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAGES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES = 2'd2;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_EVICT,
    S_FILL
  } state_t;

endpackage

// ----- rtl/pmmu_if.sv -----
// valid/ready channels for translation requests and results
interface pmmu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] vaddr;
  logic        op;

  modport source (output valid, output vaddr, output op, input ready);
  modport sink (input valid, input vaddr, input op, output ready);
endinterface

interface pmmu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] phys_addr;
  logic        illegal;
  logic        fault;
  logic        replaced;
  logic        writeback;
  logic [7:0]  evicted_page;
  logic [5:0]  frame_used;

  modport source (
    output valid, output phys_addr, output illegal, output fault,
    output replaced, output writeback, output evicted_page, output frame_used,
    input ready
  );
  modport sink (
    input valid, input phys_addr, input illegal, input fault,
    input replaced, input writeback, input evicted_page, input frame_used,
    output ready
  );
endinterface

// ----- rtl/pmmu_ram.sv -----
// generic simple dual-port ram with registered read
module pmmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/paged_mmu_fifo_replacement_unit.sv -----
// top level: paged mmu with fifo frame replacement
//
// usage
// - in_ch carries one transaction per reference: vaddr and op (0 read, 1 write)
// - out_ch returns one transaction per reference: phys_addr, flags, evicted
//   page and frame; cfg_we/cfg_idx/cfg_data set page_shift, num_pages and
//   num_frames, which the user must write only while no reference is in
//   flight; the block itself does not enforce this
// - a hit, an illegal page or a free-frame fault is loaded into the output
//   register from S_LOOKUP; an evicting fault via S_EVICT and S_FILL
// - one reference at a time (in_ch.ready is high only in S_IDLE), using the
//   page table port for lookup, victim read, victim clear, new entry write
// - after reset the page table is swept clear, one entry per cycle, over all
//   MAX_PAGES entries; in_ch.ready stays low during the sweep
// - a finished result sits in the output register while the next reference
//   is accepted; if the receiver stalls, that next reference waits in
//   S_LOOKUP before any table write until the output register frees up
module paged_mmu_fifo_replacement_unit #(
  parameter int MAX_PAGES  = pmmu_pkg::MAX_PAGES_DEF,
  parameter int MAX_FRAMES = pmmu_pkg::MAX_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pmmu_in_if.sink                          in_ch,
  pmmu_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [pmmu_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pmmu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import pmmu_pkg::*;

  localparam int PW    = $clog2(MAX_PAGES);
  localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FCW   = $clog2(MAX_FRAMES + 1);
  localparam int NW    = (FCW > NFRAMES_W) ? FCW : NFRAMES_W;
  localparam int PTE_W = FW + 2;

  state_t state_r, state_nxt;

  logic [SHIFT_W-1:0]   page_shift_r;
  logic [NPAGES_W-1:0]  num_pages_r;
  logic [NFRAMES_W-1:0] num_frames_r;

  logic [PW-1:0]  clr_r, clr_nxt;
  logic [FCW-1:0] next_free_r, next_free_nxt;
  logic [FW-1:0]  oldest_r, oldest_nxt;

  logic [VADDR_W-1:0] vaddr_r, vaddr_nxt;
  logic               op_r, op_nxt;
  logic [PW-1:0]      page_r, page_nxt;
  logic               illegal_r, illegal_nxt;
  logic [FW-1:0]      frame_r, frame_nxt;
  logic [PW-1:0]      victim_r, victim_nxt;
  logic               wb_r, wb_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [VADDR_W-1:0]     out_phys_r, out_phys_nxt;
  logic                   out_illegal_r, out_illegal_nxt;
  logic                   out_fault_r, out_fault_nxt;
  logic                   out_repl_r, out_repl_nxt;
  logic                   out_wb_r, out_wb_nxt;
  logic [EVICT_W-1:0]     out_evict_r, out_evict_nxt;
  logic [FRAME_OUT_W-1:0] out_frame_r, out_frame_nxt;

  logic             pt_we, pt_re;
  logic [PW-1:0]    pt_waddr, pt_raddr;
  logic [PTE_W-1:0] pt_wdata, pt_rdata;
  logic             ow_we, ow_re;
  logic [FW-1:0]    ow_waddr, ow_raddr;
  logic [PW-1:0]    ow_wdata, ow_rdata;

  logic [VADDR_W-1:0] in_page;
  logic               in_illegal;
  logic [NW-1:0]      nf_ext;
  logic [FCW-1:0]     nf;
  logic               out_free;
  logic [VADDR_W-1:0] offset;

  pmmu_ram #(.WIDTH(PTE_W), .DEPTH(MAX_PAGES)) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  pmmu_ram #(.WIDTH(PW), .DEPTH(MAX_FRAMES)) u_frame_owner (
    .clk   (clk),
    .we    (ow_we),
    .waddr (ow_waddr),
    .wdata (ow_wdata),
    .re    (ow_re),
    .raddr (ow_raddr),
    .rdata (ow_rdata)
  );

  assign in_page    = in_ch.vaddr >> page_shift_r;
  assign in_illegal = (in_page >= VADDR_W'(num_pages_r)) ||
                      (in_page >= VADDR_W'(MAX_PAGES));
  assign nf_ext     = (num_frames_r == '0) ? NW'(1) :
                      (NW'(num_frames_r) > NW'(MAX_FRAMES)) ? NW'(MAX_FRAMES) :
                      NW'(num_frames_r);
  assign nf         = nf_ext[FCW-1:0];
  assign out_free   = !out_valid_r || out_ch.ready;
  assign offset     = vaddr_r & ~({VADDR_W{1'b1}} << page_shift_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r <= PAGE_SHIFT_RST;
      num_pages_r  <= NUM_PAGES_RST;
      num_frames_r <= NUM_FRAMES_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PAGE_SHIFT: page_shift_r <= cfg_data[SHIFT_W-1:0];
        CFG_NUM_PAGES:  num_pages_r  <= cfg_data[NPAGES_W-1:0];
        CFG_NUM_FRAMES: num_frames_r <= cfg_data[NFRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      next_free_r <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      next_free_r <= next_free_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vaddr_r       <= vaddr_nxt;
    op_r          <= op_nxt;
    page_r        <= page_nxt;
    illegal_r     <= illegal_nxt;
    frame_r       <= frame_nxt;
    victim_r      <= victim_nxt;
    wb_r          <= wb_nxt;
    out_phys_r    <= out_phys_nxt;
    out_illegal_r <= out_illegal_nxt;
    out_fault_r   <= out_fault_nxt;
    out_repl_r    <= out_repl_nxt;
    out_wb_r      <= out_wb_nxt;
    out_evict_r   <= out_evict_nxt;
    out_frame_r   <= out_frame_nxt;
  end

  always_comb begin
    logic [FW-1:0] res_frame;
    res_frame       = frame_r;
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    next_free_nxt   = next_free_r;
    oldest_nxt      = oldest_r;
    vaddr_nxt       = vaddr_r;
    op_nxt          = op_r;
    page_nxt        = page_r;
    illegal_nxt     = illegal_r;
    frame_nxt       = frame_r;
    victim_nxt      = victim_r;
    wb_nxt          = wb_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_phys_nxt    = out_phys_r;
    out_illegal_nxt = out_illegal_r;
    out_fault_nxt   = out_fault_r;
    out_repl_nxt    = out_repl_r;
    out_wb_nxt      = out_wb_r;
    out_evict_nxt   = out_evict_r;
    out_frame_nxt   = out_frame_r;
    in_ch.ready     = 1'b0;
    pt_we           = 1'b0;
    pt_waddr        = page_r;
    pt_wdata        = '0;
    pt_re           = 1'b0;
    pt_raddr        = in_page[PW-1:0];
    ow_we           = 1'b0;
    ow_waddr        = frame_r;
    ow_wdata        = page_r;
    ow_re           = 1'b0;
    ow_raddr        = oldest_r;

    unique case (state_r)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_r;
        if (clr_r == PW'(MAX_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          vaddr_nxt   = in_ch.vaddr;
          op_nxt      = in_ch.op;
          page_nxt    = in_page[PW-1:0];
          illegal_nxt = in_illegal;
          pt_re       = 1'b1;
          ow_re       = 1'b1;
          state_nxt   = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (out_free) begin
          priority if (illegal_r) begin
            out_valid_nxt   = 1'b1;
            out_phys_nxt    = '1;
            out_illegal_nxt = 1'b1;
            out_fault_nxt   = 1'b0;
            out_repl_nxt    = 1'b0;
            out_wb_nxt      = 1'b0;
            out_evict_nxt   = '0;
            out_frame_nxt   = '0;
            state_nxt       = S_IDLE;
          end else if (pt_rdata[FW+1]) begin
            res_frame = pt_rdata[FW-1:0];
            if (op_r == OP_WRITE) begin
              pt_we    = 1'b1;
              pt_wdata = {1'b1, 1'b1, res_frame};
            end
            out_valid_nxt   = 1'b1;
            out_phys_nxt    = (VADDR_W'(res_frame) << page_shift_r) + offset;
            out_illegal_nxt = 1'b0;
            out_fault_nxt   = 1'b0;
            out_repl_nxt    = 1'b0;
            out_wb_nxt      = 1'b0;
            out_evict_nxt   = '0;
            out_frame_nxt   = FRAME_OUT_W'(res_frame);
            state_nxt       = S_IDLE;
          end else if (next_free_r < nf) begin
            res_frame       = next_free_r[FW-1:0];
            next_free_nxt   = next_free_r + 1'b1;
            pt_we           = 1'b1;
            pt_wdata        = {1'b1, op_r, res_frame};
            ow_we           = 1'b1;
            ow_waddr        = res_frame;
            out_valid_nxt   = 1'b1;
            out_phys_nxt    = (VADDR_W'(res_frame) << page_shift_r) + offset;
            out_illegal_nxt = 1'b0;
            out_fault_nxt   = 1'b1;
            out_repl_nxt    = 1'b0;
            out_wb_nxt      = 1'b0;
            out_evict_nxt   = '0;
            out_frame_nxt   = FRAME_OUT_W'(res_frame);
            state_nxt       = S_IDLE;
          end else begin
            // all frames in use: fetch the victim's entry
            victim_nxt = ow_rdata;
            frame_nxt  = oldest_r;
            pt_re      = 1'b1;
            pt_raddr   = ow_rdata;
            state_nxt  = S_EVICT;
          end
        end
      end
      S_EVICT: begin
        wb_nxt    = pt_rdata[FW];
        pt_we     = 1'b1;
        pt_waddr  = victim_r;
        pt_wdata  = {1'b0, pt_rdata[FW], pt_rdata[FW-1:0]};
        state_nxt = S_FILL;
      end
      S_FILL: begin
        if (out_free) begin
          pt_we           = 1'b1;
          pt_wdata        = {1'b1, op_r, frame_r};
          ow_we           = 1'b1;
          oldest_nxt      = ((FCW'(frame_r) + 1'b1) >= nf) ? '0 : frame_r + 1'b1;
          out_valid_nxt   = 1'b1;
          out_phys_nxt    = (VADDR_W'(frame_r) << page_shift_r) + offset;
          out_illegal_nxt = 1'b0;
          out_fault_nxt   = 1'b1;
          out_repl_nxt    = 1'b1;
          out_wb_nxt      = wb_r;
          out_evict_nxt   = EVICT_W'(victim_r);
          out_frame_nxt   = FRAME_OUT_W'(frame_r);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.phys_addr    = out_phys_r;
  assign out_ch.illegal      = out_illegal_r;
  assign out_ch.fault        = out_fault_r;
  assign out_ch.replaced     = out_repl_r;
  assign out_ch.writeback    = out_wb_r;
  assign out_ch.evicted_page = out_evict_r;
  assign out_ch.frame_used   = out_frame_r;

  a_next_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= FCW'(MAX_FRAMES))
    else $error("free frame pointer beyond frame count");

  a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    FCW'(oldest_r) < FCW'(MAX_FRAMES))
    else $error("oldest frame pointer beyond frame count");

  a_evict_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT) |-> ($past(state_r) == S_LOOKUP))
    else $error("eviction entered without a lookup");

  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> ($past(state_r) == S_EVICT || $past(state_r) == S_FILL))
    else $error("fill entered without an eviction");

  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP && state_nxt == S_EVICT) |-> (next_free_r >= nf))
    else $error("eviction while free frames remain");

endmodule

// ----- test/tb_top.sv -----
// testbench for the paged mmu with fifo frame replacement
`timescale 1ns / 1ps

module tb_top;
  import pmmu_pkg::*;

  typedef struct packed {
    logic [31:0] phys_addr;
    logic        illegal;
    logic        fault;
    logic        replaced;
    logic        writeback;
    logic [7:0]  evicted_page;
    logic [5:0]  frame_used;
  } xlat_t;

  typedef enum {ROW_REF, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [31:0]            vaddr;
    logic                   op;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    bit                     typed;
    xlat_t                  want;
  } step_t;

  typedef struct packed {
    int shift;
    int pages;
    int frames;
    int count;
    int span;
    int idle;
    bit hold;
  } phase_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pmmu_in_if  in_ch ();
  pmmu_out_if out_ch ();

  paged_mmu_fifo_replacement_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // translation state mirrored from the block
  bit          pt_present [MAX_PAGES_DEF];
  bit          pt_dirty   [MAX_PAGES_DEF];
  logic [5:0]  pt_frame   [MAX_PAGES_DEF];
  logic [7:0]  frame_page [MAX_FRAMES_DEF];
  int unsigned free_ptr;
  int unsigned fifo_ptr;
  logic [SHIFT_W-1:0]   mmu_shift;
  logic [NPAGES_W-1:0]  mmu_pages;
  logic [NFRAMES_W-1:0] mmu_frames;

  xlat_t xlat_q [$];
  step_t steps [$];
  xlat_t seen;
  int    mismatches = 0;
  int    in_idle_pct = 18;
  int    out_idle_pct = 18;
  bit    hold_req = 0;
  int    hold_left = 0;

  phase_t phases [8] = '{
    '{12, 256,  64, 250, 90, 18, 1'b0},
    '{ 4,  16,   4, 150,  8, 18, 1'b0},
    '{16, 256,   1, 100,  4, 18, 1'b0},
    '{31, 511, 127, 100,  2, 18, 1'b0},
    '{ 0,   0,   0,  50,  0, 18, 1'b0},
    '{ 8, 100,  10, 200, 16, 18, 1'b1},
    '{12,   1,  64,  50,  1, 18, 1'b0},
    '{ 5, 200,  33, 350, 50,  0, 1'b0}
  };

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic xlat_t translate(input logic [31:0] va, input logic op);
    int unsigned page, np, nf, fr, victim;
    logic [63:0] off;
    xlat_t r;
    page = va >> mmu_shift;
    off  = 64'(va) & ((64'd1 << mmu_shift) - 64'd1);
    np   = (mmu_pages > MAX_PAGES_DEF) ? MAX_PAGES_DEF : mmu_pages;
    nf   = (mmu_frames == 0) ? 1 : ((mmu_frames > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : mmu_frames);
    r = '0;
    if (page >= np) begin
      r.phys_addr = '1;
      r.illegal = 1'b1;
      return r;
    end
    if (!pt_present[page]) begin
      r.fault = 1'b1;
      if (free_ptr < nf) begin
        fr = free_ptr;
        free_ptr++;
      end else begin
        fr = fifo_ptr;
        if (fr >= MAX_FRAMES_DEF) fr = MAX_FRAMES_DEF - 1;
        victim = frame_page[fr] % MAX_PAGES_DEF;
        r.replaced = 1'b1;
        r.evicted_page = victim[7:0];
        r.writeback = pt_dirty[victim];
        pt_present[victim] = 1'b0;
        fifo_ptr = (fr + 1 >= nf) ? 0 : fr + 1;
      end
      pt_present[page] = 1'b1;
      pt_dirty[page] = 1'b0;
      pt_frame[page] = fr[5:0];
      frame_page[fr] = page[7:0];
    end
    fr = pt_frame[page];
    if (op == OP_WRITE) pt_dirty[page] = 1'b1;
    r.phys_addr = 32'((64'(fr) << mmu_shift) + off);
    r.frame_used = fr[5:0];
    return r;
  endfunction

  function automatic xlat_t res(input logic [31:0] pa, input logic ill, input logic pf,
                                input logic rep, input logic wb, input logic [7:0] ev,
                                input logic [5:0] fr);
    return {pa, ill, pf, rep, wb, ev, fr};
  endfunction

  function automatic step_t ref_row(input logic [31:0] va, input logic op);
    step_t s;
    s = '{ROW_REF, va, op, CFG_PAGE_SHIFT, '0, 1'b0, '0};
    return s;
  endfunction

  function automatic step_t chk_row(input logic [31:0] va, input logic op, input xlat_t w);
    step_t s;
    s = '{ROW_REF, va, op, CFG_PAGE_SHIFT, '0, 1'b1, w};
    return s;
  endfunction

  function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    step_t s;
    s = '{ROW_CFG, '0, OP_READ, idx, data, 1'b0, '0};
    return s;
  endfunction

  task automatic send_ref(input logic [31:0] va, input logic op, input bit typed,
                          input xlat_t want);
    xlat_t got;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.vaddr <= va;
    in_ch.op    <= op;
    do @(posedge clk); while (!in_ch.ready);
    got = translate(va, op);
    xlat_q.push_back(typed ? want : got);
  endtask

  // let every pending translation come back before touching registers
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (xlat_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    unique case (idx)
      CFG_PAGE_SHIFT: mmu_shift  = data[SHIFT_W-1:0];
      CFG_NUM_PAGES:  mmu_pages  = data[NPAGES_W-1:0];
      CFG_NUM_FRAMES: mmu_frames = data[NFRAMES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(input phase_t ph);
    int unsigned np, span, page;
    logic [63:0] va64;
    logic [31:0] va;
    np   = (mmu_pages > MAX_PAGES_DEF) ? MAX_PAGES_DEF : mmu_pages;
    span = (ph.span < np) ? ph.span : np;
    if (span == 0 || $urandom_range(99) < 10) begin
      va = $urandom();
    end else begin
      page = $urandom_range(span - 1);
      va64 = (64'(page) << mmu_shift) | (64'($urandom()) & ((64'd1 << mmu_shift) - 64'd1));
      va = va64[31:0];
    end
    send_ref(va, 1'($urandom_range(1)), 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %h actual %h", name, want, got);
      mismatches++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (xlat_q.size() == 0) begin
        $error("result transaction with no pending reference");
        mismatches++;
      end else begin
        seen = xlat_q.pop_front();
        check_field("phys_addr", seen.phys_addr, out_ch.phys_addr);
        check_field("illegal", 32'(seen.illegal), 32'(out_ch.illegal));
        check_field("fault", 32'(seen.fault), 32'(out_ch.fault));
        check_field("replaced", 32'(seen.replaced), 32'(out_ch.replaced));
        check_field("writeback", 32'(seen.writeback), 32'(out_ch.writeback));
        check_field("evicted_page", 32'(seen.evicted_page), 32'(out_ch.evicted_page));
        check_field("frame_used", 32'(seen.frame_used), 32'(out_ch.frame_used));
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.vaddr  <= '0;
    in_ch.op     <= OP_READ;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_PAGE_SHIFT;
    cfg_data     <= '0;
    mmu_shift  = PAGE_SHIFT_RST;
    mmu_pages  = NUM_PAGES_RST;
    mmu_frames = NUM_FRAMES_RST;
    free_ptr = 0;
    fifo_ptr = 0;
    foreach (pt_present[i]) begin
      pt_present[i] = 1'b0;
      pt_dirty[i]   = 1'b0;
      pt_frame[i]   = '0;
    end
    foreach (frame_page[i]) frame_page[i] = '0;

    // defaults after reset: 4 KiB pages, 256 pages, 64 frames
    steps.push_back(chk_row(32'h0000_0000, OP_READ,
                            res(32'h0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 6'd0)));
    steps.push_back(chk_row(32'hFFFF_FFFF, OP_READ,
                            res('1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 6'd0)));
    steps.push_back(chk_row(32'h0000_0FFF, OP_WRITE,
                            res(32'hFFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 6'd0)));
    steps.push_back(chk_row(32'h000F_FFFF, OP_WRITE,
                            res(32'h1FFF, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 6'd1)));
    steps.push_back(chk_row(32'h0010_0000, OP_READ,
                            res('1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 6'd0)));
    steps.push_back(chk_row(32'h8000_0000, OP_WRITE,
                            res('1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 6'd0)));
    // frame count shrunk to the number of frames already handed out
    steps.push_back(cfg_row(CFG_NUM_FRAMES, 9'd2));
    steps.push_back(chk_row(32'h0000_2000, OP_READ,
                            res(32'h0, 1'b0, 1'b1, 1'b1, 1'b1, 8'd0, 6'd0)));
    steps.push_back(chk_row(32'h0000_3004, OP_READ,
                            res(32'h1004, 1'b0, 1'b1, 1'b1, 1'b1, 8'd255, 6'd1)));
    steps.push_back(chk_row(32'h0000_2010, OP_WRITE,
                            res(32'h10, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 6'd0)));
    steps.push_back(chk_row(32'h0000_0000, OP_READ,
                            res(32'h0, 1'b0, 1'b1, 1'b1, 1'b1, 8'd2, 6'd0)));
    steps.push_back(chk_row(32'h0000_4000, OP_READ,
                            res(32'h1000, 1'b0, 1'b1, 1'b1, 1'b0, 8'd3, 6'd1)));
    // page shift of 4 and zero page count: everything illegal
    steps.push_back(cfg_row(CFG_PAGE_SHIFT, 9'd4));
    steps.push_back(cfg_row(CFG_NUM_PAGES, 9'd0));
    steps.push_back(chk_row(32'h0000_0000, OP_READ,
                            res('1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 6'd0)));
    steps.push_back(chk_row(32'hFFFF_FFFF, OP_WRITE,
                            res('1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 6'd0)));
    // page count beyond range, zero frames, widest shift
    steps.push_back(cfg_row(CFG_NUM_PAGES, 9'd511));
    steps.push_back(cfg_row(CFG_NUM_FRAMES, 9'd0));
    steps.push_back(cfg_row(CFG_PAGE_SHIFT, 9'h1FF));
    steps.push_back(ref_row(32'h8000_0001, OP_READ));
    steps.push_back(ref_row(32'h7FFF_FFFF, OP_WRITE));
    // frame count above range, zero shift
    steps.push_back(cfg_row(CFG_NUM_FRAMES, 9'd127));
    steps.push_back(cfg_row(CFG_PAGE_SHIFT, 9'h1E0));
    steps.push_back(ref_row(32'h0000_00FF, OP_WRITE));
    steps.push_back(chk_row(32'h0000_0100, OP_READ,
                            res('1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 6'd0)));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) begin
        drain();
        write_reg(steps[i].idx, steps[i].data);
        end_writes();
      end else begin
        send_ref(steps[i].vaddr, steps[i].op, steps[i].typed, steps[i].want);
      end
    end

    foreach (phases[p]) begin
      drain();
      write_reg(CFG_PAGE_SHIFT, CFG_DATA_W'(phases[p].shift));
      write_reg(CFG_NUM_PAGES, CFG_DATA_W'(phases[p].pages));
      write_reg(CFG_NUM_FRAMES, CFG_DATA_W'(phases[p].frames));
      end_writes();
      in_idle_pct  = phases[p].idle;
      out_idle_pct = phases[p].idle;
      if (phases[p].hold) hold_req = 1'b1;
      repeat (phases[p].count) send_random(phases[p]);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (xlat_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pmmu_pkg.sv
rtl/pmmu_if.sv
rtl/pmmu_ram.sv
rtl/paged_mmu_fifo_replacement_unit.sv
test/tb_top.sv
